[src/pvc_pkg.sv]
// Shared types and constants for the pump/valve command controller.
// No dependencies; imported by the controller modules and the port checker.
`timescale 1ns / 1ps
`default_nettype none

package pvc_pkg;

  localparam int unsigned CfgDataWidth  = 16;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned PValueWidth   = 16;

  typedef enum logic [2:0] {
    CMD_PUMP    = 3'd0,
    CMD_SLIDE   = 3'd1,
    CMD_PULSE   = 3'd2,
    CMD_SUCTION = 3'd3,
    CMD_TICK    = 3'd4
  } command_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MODE_OFF      = 2'd0,
    MODE_PRESSURE = 2'd1,
    MODE_VACUUM   = 2'd2
  } pump_mode_e;

  typedef enum logic [1:0] {
    REG_SILVER_DEFAULT = 2'd0,
    REG_SOLDER_DEFAULT = 2'd1,
    REG_UV_DEFAULT     = 2'd2
  } cfg_reg_e;

  localparam logic [CfgDataWidth-1:0] SilverDefaultReset = 16'd50;
  localparam logic [CfgDataWidth-1:0] SolderDefaultReset = 16'd50;
  localparam logic [CfgDataWidth-1:0] UvDefaultReset     = 16'd1000;

  // Control for one pulse channel
  typedef struct packed {
    logic load;
    logic tick;
  } pulse_ctrl_t;

endpackage

`default_nettype wire

[src/pvc_pulse.sv]
// One-shot pulse counter: loads a saturated length, counts down on ticks.
// Depends on pvc_pkg for the control struct and the length width.
`timescale 1ns / 1ps
`default_nettype none

module pvc_pulse #(
  parameter int unsigned CountBits = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire pvc_pkg::pulse_ctrl_t                  ctrl_i,
  input  wire logic [pvc_pkg::PValueWidth-1:0]       len_i,
  output logic                                       active_next_o
);
  import pvc_pkg::*;

  localparam int unsigned LenWidth = (CountBits > PValueWidth) ? CountBits : PValueWidth;

  logic [CountBits-1:0] cnt_q, cnt_d;
  logic [LenWidth-1:0]  len_ext;
  logic [LenWidth-1:0]  cnt_max_ext;
  logic [CountBits-1:0] len_sat;

  assign len_ext     = LenWidth'(len_i);
  assign cnt_max_ext = LenWidth'({CountBits{1'b1}});
  // clamp to the counter range
  assign len_sat     = (len_ext > cnt_max_ext) ? {CountBits{1'b1}} : CountBits'(len_ext);

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      cnt_d = len_sat;
    end else if (ctrl_i.tick && (cnt_q != '0)) begin
      cnt_d = cnt_q - CountBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign active_next_o = (cnt_d != '0);

endmodule

`default_nettype wire

[src/pump_valve_command_controller_top.sv]
// A result is valid the cycle after its transaction is accepted.
// Throughput: one item per cycle; the input stays ready while the result
// register is empty or being drained in the same cycle.
// Reset (async, active low): pump off, airslides, suction and pulses cleared,
// pulse defaults back to 50 / 50 / 1000 ticks, no result pending.
// Depends on pvc_pkg and pvc_pulse.
`timescale 1ns / 1ps
`default_nettype none

module pump_valve_command_controller_top #(
  parameter int unsigned PULSE_COUNT_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [pvc_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  wire logic [pvc_pkg::CfgDataWidth-1:0]    cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [2:0]                          command_i,
  input  wire logic                                check_only_i,
  input  wire logic                                p_given_i,
  input  wire logic [pvc_pkg::PValueWidth-1:0]     p_value_i,
  input  wire logic                                y_given_i,
  input  wire logic [1:0]                          y_value_i,
  input  wire logic                                x_given_i,
  input  wire logic [1:0]                          x_value_i,
  input  wire logic                                z_given_i,
  input  wire logic [1:0]                          z_value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [1:0]                               status_o,
  output logic                                     air_pump_on_o,
  output logic                                     inlet_valve_on_o,
  output logic                                     outlet_valve_on_o,
  output logic                                     airslide_one_on_o,
  output logic                                     airslide_two_on_o,
  output logic                                     silver_clamp_on_o,
  output logic                                     solder_clamp_on_o,
  output logic                                     uv_lamp_on_o,
  output logic                                     suction_on_o
);
  import pvc_pkg::*;

  logic out_valid_q;
  logic in_fire;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // configuration registers
  logic [CfgDataWidth-1:0] silver_def_q, solder_def_q, uv_def_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      silver_def_q <= SilverDefaultReset;
      solder_def_q <= SolderDefaultReset;
      uv_def_q     <= UvDefaultReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SILVER_DEFAULT: silver_def_q <= cfg_data_i;
        REG_SOLDER_DEFAULT: solder_def_q <= cfg_data_i;
        REG_UV_DEFAULT:     uv_def_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // architectural state
  pump_mode_e mode_q, mode_d;
  logic slide_one_q, slide_one_d;
  logic slide_two_q, slide_two_d;
  logic suction_q, suction_d;

  status_e     status_d;
  pulse_ctrl_t silver_ctrl, solder_ctrl, uv_ctrl;
  logic [PValueWidth-1:0] silver_len, solder_len, uv_len;
  logic        one_sel;
  logic [1:0]  sel_value;
  logic        do_exec;

  assign one_sel = ({y_given_i, x_given_i, z_given_i} == 3'b100) ||
                   ({y_given_i, x_given_i, z_given_i} == 3'b010) ||
                   ({y_given_i, x_given_i, z_given_i} == 3'b001);
  assign sel_value = y_given_i ? y_value_i : (x_given_i ? x_value_i : z_value_i);

  assign silver_len = p_given_i ? p_value_i : silver_def_q;
  assign solder_len = p_given_i ? p_value_i : solder_def_q;
  assign uv_len     = p_given_i ? p_value_i : uv_def_q;

  // validation
  always_comb begin
    status_d = ST_OK;
    case (command_i)
      CMD_PUMP: begin
        if (!p_given_i) begin
          status_d = ST_INVALID;
        end else if (p_value_i > PValueWidth'(2)) begin
          status_d = ST_RANGE;
        end
      end
      CMD_SLIDE: begin
        if (!y_given_i && !x_given_i) begin
          status_d = ST_INVALID;
        end else if (y_given_i && y_value_i > 2'd1) begin
          status_d = ST_RANGE;
        end else if (x_given_i && x_value_i > 2'd1) begin
          status_d = ST_RANGE;
        end else if (((y_given_i && y_value_i == 2'd1) || (x_given_i && x_value_i == 2'd1))
                     && mode_q != MODE_PRESSURE) begin
          status_d = ST_INVALID;
        end
      end
      CMD_PULSE: begin
        if (!one_sel) begin
          status_d = ST_INVALID;
        end else if (p_given_i && p_value_i == '0) begin
          status_d = ST_RANGE;
        end else if (sel_value != 2'd1) begin
          status_d = ST_RANGE;
        end
      end
      CMD_SUCTION: begin
        if (!p_given_i) begin
          status_d = ST_INVALID;
        end else if (p_value_i > PValueWidth'(1)) begin
          status_d = ST_RANGE;
        end else if (p_value_i == PValueWidth'(1) && mode_q != MODE_VACUUM) begin
          status_d = ST_INVALID;
        end
      end
      CMD_TICK: status_d = ST_OK;
      default:  status_d = ST_INVALID;
    endcase
  end

  assign do_exec = in_fire && (status_d == ST_OK) && !check_only_i;

  // execution
  always_comb begin
    mode_d      = mode_q;
    slide_one_d = slide_one_q;
    slide_two_d = slide_two_q;
    suction_d   = suction_q;
    silver_ctrl = '0;
    solder_ctrl = '0;
    uv_ctrl     = '0;
    case (command_i)
      CMD_PUMP: begin
        if (do_exec) mode_d = pump_mode_e'(p_value_i[1:0]);
      end
      CMD_SLIDE: begin
        if (do_exec && y_given_i) slide_one_d = y_value_i[0];
        if (do_exec && x_given_i) slide_two_d = x_value_i[0];
      end
      CMD_PULSE: begin
        silver_ctrl.load = do_exec && y_given_i;
        solder_ctrl.load = do_exec && x_given_i;
        uv_ctrl.load     = do_exec && z_given_i;
      end
      CMD_SUCTION: begin
        if (do_exec) suction_d = p_value_i[0];
      end
      CMD_TICK: begin
        // a tick ignores check_only
        silver_ctrl.tick = in_fire;
        solder_ctrl.tick = in_fire;
        uv_ctrl.tick     = in_fire;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_OFF;
      slide_one_q <= 1'b0;
      slide_two_q <= 1'b0;
      suction_q   <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      slide_one_q <= slide_one_d;
      slide_two_q <= slide_two_d;
      suction_q   <= suction_d;
    end
  end

  logic silver_act_d, solder_act_d, uv_act_d;

  pvc_pulse #(.CountBits(PULSE_COUNT_BITS)) u_silver (
    .clk_i, .rst_ni, .ctrl_i(silver_ctrl), .len_i(silver_len), .active_next_o(silver_act_d)
  );
  pvc_pulse #(.CountBits(PULSE_COUNT_BITS)) u_solder (
    .clk_i, .rst_ni, .ctrl_i(solder_ctrl), .len_i(solder_len), .active_next_o(solder_act_d)
  );
  pvc_pulse #(.CountBits(PULSE_COUNT_BITS)) u_uv (
    .clk_i, .rst_ni, .ctrl_i(uv_ctrl), .len_i(uv_len), .active_next_o(uv_act_d)
  );

  // result register
  status_e    status_q;
  pump_mode_e res_mode_q;
  logic       res_slide_one_q, res_slide_two_q, res_suction_q;
  logic       res_silver_q, res_solder_q, res_uv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q        <= status_d;
      res_mode_q      <= mode_d;
      res_slide_one_q <= slide_one_d;
      res_slide_two_q <= slide_two_d;
      res_suction_q   <= suction_d;
      res_silver_q    <= silver_act_d;
      res_solder_q    <= solder_act_d;
      res_uv_q        <= uv_act_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign air_pump_on_o     = (res_mode_q != MODE_OFF);
  assign inlet_valve_on_o  = (res_mode_q == MODE_VACUUM);
  assign outlet_valve_on_o = (res_mode_q == MODE_PRESSURE);
  assign airslide_one_on_o = res_slide_one_q;
  assign airslide_two_on_o = res_slide_two_q;
  assign silver_clamp_on_o = res_silver_q;
  assign solder_clamp_on_o = res_solder_q;
  assign uv_lamp_on_o      = res_uv_q;
  assign suction_on_o      = res_suction_q;

endmodule

`default_nettype wire

[src/pvc_checker.sv]
// Port-level checks for the pump/valve command controller, bound to the top.
// Depends on pvc_pkg for the status codes.
`timescale 1ns / 1ps
`default_nettype none

module pvc_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic [1:0]                        status_o,
  input wire logic                              air_pump_on_o,
  input wire logic                              inlet_valve_on_o,
  input wire logic                              outlet_valve_on_o
);
  import pvc_pkg::*;

  // every accepted transaction yields a result next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result after accepted transaction");

  // a pending result blocks input unless it drains this cycle
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input ready while result stalled");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("stalled result dropped or changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_INVALID || status_o == ST_RANGE))
    else $error("undefined status code");

  // pump runs with exactly one of the two valves open
  a_pump_valves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (air_pump_on_o == (inlet_valve_on_o ^ outlet_valve_on_o))
                    && !(inlet_valve_on_o && outlet_valve_on_o))
    else $error("pump and valve outputs disagree");

endmodule

bind pump_valve_command_controller_top pvc_checker u_pvc_checker (
  .clk_i,
  .rst_ni,
  .in_valid_i,
  .in_ready_o,
  .out_valid_o,
  .out_ready_i,
  .status_o,
  .air_pump_on_o,
  .inlet_valve_on_o,
  .outlet_valve_on_o
);

`default_nettype wire
